// ===== design/lmc_pkg.sv =====
// Shared types, constants and helper function of the Luhn mod-10 check block.
package lmc_pkg;

  localparam int unsigned NUM_W  = 64;
  localparam int unsigned CONV_W = $clog2(NUM_W);

  // Largest account number whose product with ten still fits in 64 bits.
  localparam logic [NUM_W-1:0] OVF_LIMIT = 64'd1844674407370955161;

  typedef enum logic [1:0] {
    CMD_VALIDATE = 2'd0,
    CMD_CHECKSUM = 2'd1,
    CMD_GENERATE = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_CLEAR,
    CELL_CONV,
    CELL_SHIFT,
    CELL_HOLD
  } cell_mode_t;

  // Doubled decimal digit folded back to its digit sum.
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [3:0] r;
    if (d < 4'd5) begin
      r = {d[2:0], 1'b0};
    end else begin
      r = {d[2:0], 1'b0} - 4'd9;
    end
    return r;
  endfunction

endpackage

// ===== design/lmc_if.sv =====
// Valid/ready channel interfaces for the input and result sides.
interface lmc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [lmc_pkg::NUM_W-1:0] acct_num;
  logic                      strip_last;

  modport source (output valid, cmd, acct_num, strip_last, input ready);
  modport sink   (input valid, cmd, acct_num, strip_last, output ready);
endinterface

interface lmc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic       valid_res;
  logic       overflow;

  modport source (output valid, digit, valid_res, overflow, input ready);
  modport sink   (input valid, digit, valid_res, overflow, output ready);
endinterface

// ===== design/lmc_cell.sv =====
// One BCD digit cell: shift-add-3 conversion step and digit shift toward the low end.
module lmc_cell (
  input  logic                clk,
  input  lmc_pkg::cell_mode_t mode,
  input  logic                bit_in,
  input  logic [3:0]          dig_in,
  output logic                bit_out,
  output logic [3:0]          dig
);

  logic [3:0] dig_r;
  logic [3:0] dig_nxt;
  logic [3:0] adj;

  assign adj     = (dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
  assign bit_out = adj[3];
  assign dig     = dig_r;

  always_comb begin
    unique case (mode)
      lmc_pkg::CELL_CLEAR: dig_nxt = 4'd0;
      lmc_pkg::CELL_CONV:  dig_nxt = {adj[2:0], bit_in};
      lmc_pkg::CELL_SHIFT: dig_nxt = dig_in;
      lmc_pkg::CELL_HOLD:  dig_nxt = dig_r;
      default:             dig_nxt = dig_r;
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

// ===== design/luhn_mod10_check_top.sv =====
// Luhn mod-10 check block: binary to decimal chain of digit cells and a serial checksum.
// Each item passes the transfer, the conversion of all 64 bits, a drop step when the
// checksum command drops the last digit, the summing of MAX_DIGITS places and the load
// of the result register, in that order.
// Overflowing generate and the unused command skip the work and go straight to done.
// One item is in work at a time; rst_n (synchronous, active low) returns to idle.
module luhn_mod10_check_top #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  lmc_in_if.sink    in_ch,
  lmc_out_if.source out_ch
);

  // One cell more than the digit limit, so that the checksum command can drop the
  // lowest digit and still see MAX_DIGITS digits above it.
  localparam int unsigned NCELL = MAX_DIGITS + 1;
  localparam int unsigned PL_W  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_DROP,
    S_SUM,
    S_DONE
  } state_t;

  state_t                     state_r;
  logic [lmc_pkg::NUM_W-1:0]  bin_r;
  logic [lmc_pkg::CONV_W-1:0] cnt_r;
  logic [PL_W-1:0]            pl_r;
  logic [3:0]                 acc_r;
  logic [1:0]                 cmd_r;
  logic                       ovf_r;
  logic                       zfirst_r;
  logic                       drop_r;
  logic                       out_valid_r;
  logic [3:0]                 out_digit_r;
  logic                       out_valid_res_r;
  logic                       out_overflow_r;

  logic                in_fire;
  logic                out_fire;
  logic                load_out;
  logic                in_ovf;
  lmc_pkg::cell_mode_t mode;
  logic [3:0]          term;
  logic [4:0]          acc_sum;
  logic [3:0]          acc_nxt;
  logic [3:0]          gen_digit;

  logic       cbit [NCELL];
  logic [3:0] digs [NCELL];

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // The result register takes a new result when it is empty or is being emptied
  // by a transfer in the same cycle.
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.digit     = out_digit_r;
  assign out_ch.valid_res = out_valid_res_r;
  assign out_ch.overflow  = out_overflow_r;

  assign in_ovf = (in_ch.cmd == lmc_pkg::CMD_GENERATE) &&
                  (in_ch.acct_num > lmc_pkg::OVF_LIMIT);

  // The cells are cleared on the transfer, run shift-add-3 while the binary word
  // streams in from its top bit, and then hand digits down toward cell zero.
  always_comb begin
    unique case (state_r)
      S_IDLE:  mode = in_fire ? lmc_pkg::CELL_CLEAR : lmc_pkg::CELL_HOLD;
      S_CONV:  mode = lmc_pkg::CELL_CONV;
      S_DROP:  mode = lmc_pkg::CELL_SHIFT;
      S_SUM:   mode = zfirst_r ? lmc_pkg::CELL_HOLD : lmc_pkg::CELL_SHIFT;
      default: mode = lmc_pkg::CELL_HOLD;
    endcase
  end

  assign cbit[0] = bin_r[lmc_pkg::NUM_W-1];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [3:0] upper;
    logic       carry;
    if (i == NCELL - 1) begin : g_top
      assign upper = 4'd0;
    end else begin : g_mid
      assign upper = digs[i+1];
    end
    lmc_cell u_cell (
      .clk     (clk),
      .mode    (mode),
      .bit_in  (cbit[i]),
      .dig_in  (upper),
      .bit_out (carry),
      .dig     (digs[i])
    );
    if (i < NCELL - 1) begin : g_link
      assign cbit[i+1] = carry;
    end
  end

  // Every odd place is doubled and folded. The place for the appended zero of the
  // generate command contributes nothing and leaves the chain in place.
  always_comb begin
    if (zfirst_r) begin
      term = 4'd0;
    end else if (pl_r[0]) begin
      term = lmc_pkg::luhn_dbl(digs[0]);
    end else begin
      term = digs[0];
    end
    acc_sum = {1'b0, acc_r} + {1'b0, term};
    if (acc_sum >= 5'd10) begin
      acc_nxt = 4'(acc_sum - 5'd10);
    end else begin
      acc_nxt = acc_sum[3:0];
    end
    gen_digit = (acc_r == 4'd0) ? 4'd0 : 4'd10 - acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            bin_r    <= in_ch.acct_num;
            cmd_r    <= in_ch.cmd;
            ovf_r    <= in_ovf;
            zfirst_r <= (in_ch.cmd == lmc_pkg::CMD_GENERATE) && !in_ch.strip_last;
            drop_r   <= (in_ch.cmd == lmc_pkg::CMD_CHECKSUM) && in_ch.strip_last;
            cnt_r    <= '0;
            pl_r     <= '0;
            acc_r    <= 4'd0;
            if (in_ovf || (in_ch.cmd == lmc_pkg::CMD_UNUSED)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_CONV;
            end
          end
        end
        S_CONV: begin
          bin_r <= {bin_r[lmc_pkg::NUM_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == lmc_pkg::CONV_W'(lmc_pkg::NUM_W - 1)) begin
            state_r <= drop_r ? S_DROP : S_SUM;
          end
        end
        S_DROP: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          acc_r    <= acc_nxt;
          zfirst_r <= 1'b0;
          pl_r     <= pl_r + 1'b1;
          if (pl_r == PL_W'(MAX_DIGITS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
            if (ovf_r) begin
              out_digit_r     <= 4'd0;
              out_valid_res_r <= 1'b0;
              out_overflow_r  <= 1'b1;
            end else begin
              out_overflow_r <= 1'b0;
              unique case (cmd_r)
                lmc_pkg::CMD_VALIDATE, lmc_pkg::CMD_CHECKSUM: begin
                  out_digit_r     <= acc_r;
                  out_valid_res_r <= (acc_r == 4'd0);
                end
                lmc_pkg::CMD_GENERATE: begin
                  out_digit_r     <= gen_digit;
                  out_valid_res_r <= (acc_r == 4'd0);
                end
                default: begin
                  out_digit_r     <= 4'd0;
                  out_valid_res_r <= 1'b0;
                end
              endcase
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result appears only on the cycle after the done state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  // The lowest cell always holds a decimal digit while an item is in work.
  a_cell_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV || state_r == S_DROP || state_r == S_SUM) |-> (digs[0] <= 4'd9))
    else $error("lowest cell holds a non-decimal code");

  // The running checksum stays reduced modulo ten.
  a_acc_mod10: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM || state_r == S_DONE) |-> (acc_r <= 4'd9))
    else $error("checksum accumulator out of range");

  // A transfer on the input side closes the port until the item is finished.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while an item is in work");

endmodule
